[design/mwct_pkg.sv]
// Package: constants, status codes and types for the morph weight channel table.
`timescale 1ns / 1ps
`default_nettype none
package mwct_pkg;
  localparam int unsigned EntitySlots = 256;
  localparam int unsigned Channels    = 16;
  localparam int unsigned EW = $clog2(EntitySlots);
  localparam int unsigned CW = $clog2(Channels);
  localparam int unsigned NW = $clog2(Channels + 1);
  localparam int unsigned UW = $clog2(EntitySlots + 1);
  localparam logic signed [15:0] WMax = 16'sd16384;

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_APPENDED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_REJECTED = 3'd3,
    ST_NO_SLOT  = 3'd4,
    ST_DISABLED = 3'd5,
    ST_CHANNEL  = 3'd6,
    ST_NONE     = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EKEY, S_ECMP, S_CNT, S_CHRD, S_CHCMP, S_MIN, S_DECIDE,
    S_RDEMIT, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] hash;
    logic [15:0] weight;
    logic [3:0]  index;
    logic [4:0]  count;
    logic        last;
  } result_t;

  function automatic logic [15:0] abs16(logic signed [15:0] w);
    abs16 = w[15] ? 16'(-w) : w;
  endfunction
endpackage
`default_nettype wire

[design/mwct_store.sv]
// Entity key, channel count and channel entry memories with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module mwct_store (
  input  wire logic                         clk_i,
  input  wire logic [mwct_pkg::EW-1:0]      ek_addr_i,
  input  wire logic                         ek_we_i,
  input  wire logic [15:0]                  ek_wdata_i,
  output logic      [15:0]                  ek_rdata_o,
  input  wire logic                         cn_we_i,
  input  wire logic [mwct_pkg::NW-1:0]      cn_wdata_i,
  output logic      [mwct_pkg::NW-1:0]      cn_rdata_o,
  input  wire logic [mwct_pkg::EW+mwct_pkg::CW-1:0] ch_addr_i,
  input  wire logic                         ch_we_i,
  input  wire logic [30:0]                  ch_whash_i,
  input  wire logic [15:0]                  ch_wweight_i,
  output logic      [30:0]                  ch_rhash_o,
  output logic      [15:0]                  ch_rweight_o
);
  logic [15:0]             ek_mem [mwct_pkg::EntitySlots];
  logic [mwct_pkg::NW-1:0] cn_mem [mwct_pkg::EntitySlots];
  logic [46:0]             ch_mem [mwct_pkg::EntitySlots*mwct_pkg::Channels];

  always_ff @(posedge clk_i) begin
    if (ek_we_i) ek_mem[ek_addr_i] <= ek_wdata_i;
    ek_rdata_o <= ek_mem[ek_addr_i];
  end
  always_ff @(posedge clk_i) begin
    if (cn_we_i) cn_mem[ek_addr_i] <= cn_wdata_i;
    cn_rdata_o <= cn_mem[ek_addr_i];
  end
  always_ff @(posedge clk_i) begin
    if (ch_we_i) ch_mem[ch_addr_i] <= {ch_whash_i, ch_wweight_i};
    {ch_rhash_o, ch_rweight_o} <= ch_mem[ch_addr_i];
  end
endmodule
`default_nettype wire

[design/morph_weight_channel_table_top.sv]
// Top level of the morph weight channel table: sequencer, compare unit and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. A set scans the used entity slots one at a time
// (memory read, then key compare), then the entity's channels one at a
// time (hash compare, tracking the smallest absolute weight for a full
// record), then writes unless rejected. A read scans the entity slots the
// same way, then emits the channels one by one, each waiting in the output
// register until taken. Clear and disabled sets are answered from idle.
// s_axis_tready is high only while idle with the output register empty.
// No clearing pass after reset.
module morph_weight_channel_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,      // morph_enable
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: entity_key[15:0], channel_hash[46:16], weight[62:47], zero[63]
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,     // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: out_hash[30:0], out_weight[46:31], out_index[50:47], out_count[55:51]
  output logic [55:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,     // status
  output logic             m_axis_tlast
);
  localparam int unsigned EW = mwct_pkg::EW;
  localparam int unsigned CW = mwct_pkg::CW;
  localparam int unsigned NW = mwct_pkg::NW;
  localparam int unsigned UW = mwct_pkg::UW;

  mwct_pkg::state_e state_q, state_d;
  logic enable_q;
  logic [UW-1:0] used_q, used_d;
  logic [1:0] mode_q, mode_d;
  logic [15:0] key_q, key_d;
  logic [30:0] hash_q, hash_d;
  logic signed [15:0] w_q, w_d;
  logic [UW-1:0] ei_q, ei_d;
  logic [NW-1:0] ci_q, ci_d, held_q, held_d;
  logic [CW-1:0] ri_q, ri_d;
  logic [15:0] rabs_q, rabs_d;
  logic ovalid_q, ovalid_d;
  mwct_pkg::result_t res_q, res_d;

  logic [15:0] ek_rdata, ch_rweight;
  logic [NW-1:0] cn_rdata;
  logic [30:0] ch_rhash;
  logic ek_we, cn_we, ch_we;
  logic [NW-1:0] cn_wdata;
  logic [CW-1:0] ch_slot;
  logic [EW+CW-1:0] ch_addr;
  logic [NW-1:0] held_c;
  logic signed [15:0] wclamp;
  logic [15:0] a_cur;

  assign held_c  = (cn_rdata > NW'(mwct_pkg::Channels)) ? NW'(mwct_pkg::Channels) : cn_rdata;
  assign ch_addr = {ei_q[EW-1:0], ch_slot};
  assign a_cur   = mwct_pkg::abs16(ch_rweight);
  always_comb begin
    if (s_axis_tdata[62:47] > 16'sh4000 && !s_axis_tdata[62]) wclamp = mwct_pkg::WMax;
    else if (s_axis_tdata[62] && $signed(s_axis_tdata[62:47]) < -mwct_pkg::WMax)
      wclamp = -mwct_pkg::WMax;
    else wclamp = s_axis_tdata[62:47];
  end

  mwct_store u_store (
    .clk_i, .ek_addr_i(ei_q[EW-1:0]), .ek_we_i(ek_we), .ek_wdata_i(key_q),
    .ek_rdata_o(ek_rdata), .cn_we_i(cn_we), .cn_wdata_i(cn_wdata), .cn_rdata_o(cn_rdata),
    .ch_addr_i(ch_addr), .ch_we_i(ch_we), .ch_whash_i(hash_q), .ch_wweight_i(w_q),
    .ch_rhash_o(ch_rhash), .ch_rweight_o(ch_rweight)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mwct_pkg::S_IDLE;
      enable_q <= 1'b0;
      used_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; key_q <= key_d; hash_q <= hash_d; w_q <= w_d;
    ei_q <= ei_d; ci_q <= ci_d; held_q <= held_d; ri_q <= ri_d;
    rabs_q <= rabs_d; res_q <= res_d;
  end

  always_comb begin
    state_d = state_q; used_d = used_q; mode_d = mode_q; key_d = key_q;
    hash_d = hash_q; w_d = w_q; ei_d = ei_q; ci_d = ci_q; held_d = held_q;
    ri_d = ri_q; rabs_d = rabs_q; res_d = res_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ek_we = 1'b0; cn_we = 1'b0; ch_we = 1'b0; cn_wdata = held_q;
    ch_slot = ci_q[CW-1:0];
    s_axis_tready = (state_q == mwct_pkg::S_IDLE) && !ovalid_q;
    case (state_q)
      mwct_pkg::S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          mode_d = s_axis_tuser; key_d = s_axis_tdata[15:0];
          hash_d = s_axis_tdata[46:16]; w_d = wclamp;
          ei_d = '0; ci_d = '0;
          res_d = '{status: mwct_pkg::ST_NONE, hash: '0, weight: '0, index: '0,
                    count: '0, last: 1'b1};
          case (mwct_pkg::mode_e'(s_axis_tuser))
            mwct_pkg::MODE_SET: begin
              if (!enable_q) begin
                res_d.status = mwct_pkg::ST_DISABLED; ovalid_d = 1'b1;
              end else state_d = mwct_pkg::S_EKEY;
            end
            mwct_pkg::MODE_READ:  state_d = mwct_pkg::S_EKEY;
            mwct_pkg::MODE_CLEAR: begin used_d = '0; ovalid_d = 1'b1; end
            default: ovalid_d = 1'b1;
          endcase
        end
      end
      mwct_pkg::S_EKEY: begin
        if (ei_q >= used_q) begin
          if (mode_q == mwct_pkg::MODE_READ) begin
            ovalid_d = 1'b1; state_d = mwct_pkg::S_IDLE;
          end else if (used_q >= UW'(mwct_pkg::EntitySlots)) begin
            res_d.status = mwct_pkg::ST_NO_SLOT; ovalid_d = 1'b1;
            state_d = mwct_pkg::S_IDLE;
          end else begin
            ek_we = 1'b1; cn_we = 1'b1; cn_wdata = '0; used_d = used_q + 1'b1;
            held_d = '0; state_d = mwct_pkg::S_CHRD;
          end
        end else state_d = mwct_pkg::S_ECMP;
      end
      mwct_pkg::S_ECMP: begin
        if (ek_rdata == key_q) state_d = mwct_pkg::S_CNT;
        else begin ei_d = ei_q + 1'b1; state_d = mwct_pkg::S_EKEY; end
      end
      mwct_pkg::S_CNT: begin
        held_d = held_c;
        if (mode_q == mwct_pkg::MODE_READ) begin
          if (held_c == '0) begin ovalid_d = 1'b1; state_d = mwct_pkg::S_IDLE; end
          else state_d = mwct_pkg::S_RDEMIT;
        end else state_d = mwct_pkg::S_CHRD;
      end
      mwct_pkg::S_CHRD: begin
        if (ci_q >= held_q) state_d = mwct_pkg::S_DECIDE;
        else state_d = mwct_pkg::S_CHCMP;
      end
      mwct_pkg::S_CHCMP: begin
        if (ch_rhash == hash_q) begin
          ch_we = 1'b1;
          res_d.status = mwct_pkg::ST_UPDATED; res_d.weight = w_q;
          res_d.index = 4'(ci_q); res_d.count = 5'(held_q);
          ovalid_d = 1'b1; state_d = mwct_pkg::S_IDLE;
        end else begin
          if (ci_q == '0 || a_cur < rabs_q) begin
            ri_d = ci_q[CW-1:0]; rabs_d = a_cur;
          end
          ci_d = ci_q + 1'b1; state_d = mwct_pkg::S_CHRD;
        end
      end
      mwct_pkg::S_DECIDE: begin
        res_d.count = 5'(held_q);
        if (held_q < NW'(mwct_pkg::Channels)) begin
          ch_slot = held_q[CW-1:0]; ch_we = 1'b1; cn_we = 1'b1;
          cn_wdata = held_q + 1'b1;
          res_d.status = mwct_pkg::ST_APPENDED; res_d.weight = w_q;
          res_d.index = 4'(held_q); res_d.count = 5'(held_q + 1'b1);
        end else if (mwct_pkg::abs16(w_q) > rabs_q) begin
          ch_slot = ri_q; ch_we = 1'b1;
          res_d.status = mwct_pkg::ST_REPLACED; res_d.weight = w_q;
          res_d.index = 4'(ri_q);
        end else res_d.status = mwct_pkg::ST_REJECTED;
        ovalid_d = 1'b1; state_d = mwct_pkg::S_IDLE;
      end
      mwct_pkg::S_RDEMIT: begin
        if (!ovalid_q) state_d = mwct_pkg::S_OUT;
      end
      mwct_pkg::S_OUT: begin
        res_d = '{status: mwct_pkg::ST_CHANNEL, hash: ch_rhash, weight: ch_rweight,
                  index: 4'(ci_q), count: 5'(held_q), last: (ci_q + 1'b1 == held_q)};
        ovalid_d = 1'b1; ci_d = ci_q + 1'b1;
        state_d = (ci_q + 1'b1 == held_q) ? mwct_pkg::S_IDLE : mwct_pkg::S_RDEMIT;
      end
      default: state_d = mwct_pkg::S_IDLE;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {res_q.count, res_q.index, res_q.weight, res_q.hash};

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(mwct_pkg::EntitySlots)) else $error("entity count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mwct_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwct_pkg::S_DECIDE) |-> held_q <= NW'(mwct_pkg::Channels))
    else $error("held count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> $stable(res_q)) else $error("result changed");
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the morph weight channel table: stream driver, result monitor and scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  // Scoreboard: shadow copy of the two-level table and the queue of
  // expected results for every accepted transaction.
  class morph_table_model;
    bit                 enable;
    logic [15:0]        ent_key[mwct_pkg::EntitySlots];
    int                 ch_held[mwct_pkg::EntitySlots];
    logic [30:0]        ch_hash[mwct_pkg::EntitySlots*mwct_pkg::Channels];
    logic signed [15:0] ch_wt[mwct_pkg::EntitySlots*mwct_pkg::Channels];
    int                 ent_used;
    mwct_pkg::result_t  expected_q[$];
    int                 errors;

    function void push(mwct_pkg::status_e st, logic [30:0] h, logic signed [15:0] w,
                       int idx, int cnt, bit lst);
      mwct_pkg::result_t r;
      r.status = st;
      r.hash   = h;
      r.weight = w;
      r.index  = idx[3:0];
      r.count  = cnt[4:0];
      r.last   = lst;
      expected_q.push_back(r);
    endfunction

    function int find_entity(logic [15:0] key);
      for (int i = 0; i < ent_used; i++)
        if (ent_key[i] == key) return i;
      return -1;
    endfunction

    function int absw(logic signed [15:0] w);
      int v;
      v = w;
      return (v < 0) ? -v : v;
    endfunction

    function void note_item(logic [1:0] mode, logic [15:0] key, logic [30:0] h,
                            logic signed [15:0] w_in);
      int e, c, base, ri, rabs;
      logic signed [15:0] w;
      if (mode == mwct_pkg::MODE_SET) begin
        if (!enable) begin
          push(mwct_pkg::ST_DISABLED, '0, '0, 0, 0, 1'b1);
          return;
        end
        e = find_entity(key);
        if (e < 0) begin
          if (ent_used >= mwct_pkg::EntitySlots) begin
            push(mwct_pkg::ST_NO_SLOT, '0, '0, 0, 0, 1'b1);
            return;
          end
          e = ent_used;
          ent_key[e] = key;
          ch_held[e] = 0;
          ent_used++;
        end
        w = (w_in > mwct_pkg::WMax) ? mwct_pkg::WMax :
            (w_in < -mwct_pkg::WMax) ? -mwct_pkg::WMax : w_in;
        base = e * mwct_pkg::Channels;
        c = ch_held[e];
        for (int i = 0; i < c; i++)
          if (ch_hash[base+i] == h) begin
            ch_wt[base+i] = w;
            push(mwct_pkg::ST_UPDATED, '0, w, i, c, 1'b1);
            return;
          end
        if (c < mwct_pkg::Channels) begin
          ch_hash[base+c] = h;
          ch_wt[base+c]   = w;
          ch_held[e]      = c + 1;
          push(mwct_pkg::ST_APPENDED, '0, w, c, c + 1, 1'b1);
          return;
        end
        // full record: lowest slot with the smallest magnitude loses
        ri = 0;
        rabs = absw(ch_wt[base]);
        for (int i = 1; i < c; i++)
          if (absw(ch_wt[base+i]) < rabs) begin
            ri = i;
            rabs = absw(ch_wt[base+i]);
          end
        if (absw(w) > rabs) begin
          ch_hash[base+ri] = h;
          ch_wt[base+ri]   = w;
          push(mwct_pkg::ST_REPLACED, '0, w, ri, c, 1'b1);
        end else begin
          push(mwct_pkg::ST_REJECTED, '0, '0, 0, c, 1'b1);
        end
      end else if (mode == mwct_pkg::MODE_READ) begin
        e = find_entity(key);
        if (e < 0 || ch_held[e] == 0) begin
          push(mwct_pkg::ST_NONE, '0, '0, 0, 0, 1'b1);
          return;
        end
        base = e * mwct_pkg::Channels;
        c = ch_held[e];
        for (int i = 0; i < c; i++)
          push(mwct_pkg::ST_CHANNEL, ch_hash[base+i], ch_wt[base+i], i, c, i == c - 1);
      end else begin
        if (mode == mwct_pkg::MODE_CLEAR) ent_used = 0;
        push(mwct_pkg::ST_NONE, '0, '0, 0, 0, 1'b1);
      end
    endfunction

    function void check_result(mwct_pkg::result_t got);
      mwct_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d", got.status);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.hash !== exp.hash) begin
        $error("out_hash: expected %h, got %h", exp.hash, got.hash); errors++;
      end
      if (got.weight !== exp.weight) begin
        $error("out_weight: expected %h, got %h", exp.weight, got.weight); errors++;
      end
      if (got.index !== exp.index) begin
        $error("out_index: expected %0d, got %0d", exp.index, got.index); errors++;
      end
      if (got.count !== exp.count) begin
        $error("out_count: expected %0d, got %0d", exp.count, got.count); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  morph_table_model table_sb = new();
  bit quiet;          // no idling on either side
  bit long_hold_req;  // ask the receiver for one long stall

  morph_weight_channel_table_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("[morph_weight_channel_table_top] ERROR");
    $finish;
  end

  // Receiver: check each accepted result, stall in random bursts.
  initial begin
    mwct_pkg::result_t got;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.hash   = m_axis_tdata[30:0];
        got.weight = m_axis_tdata[46:31];
        got.index  = m_axis_tdata[50:47];
        got.count  = m_axis_tdata[55:51];
        got.last   = m_axis_tlast;
        table_sb.check_result(got);
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        stall_left = 300;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] mode, logic [15:0] key, logic [30:0] h,
                           logic [15:0] w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {1'b0, w, h, key};
    do @(posedge clk_i); while (!s_axis_tready);
    table_sb.note_item(mode, key, h, w);
  endtask

  // Config writes only once every pending result has been taken.
  task automatic write_enable(bit en);
    s_axis_tvalid <= 1'b0;
    while (table_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    table_sb.enable = en;
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int n);
    logic [1:0]  mode;
    logic [15:0] key, w;
    logic [30:0] h;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      mode = (sel < 62) ? mwct_pkg::MODE_SET : (sel < 90) ? mwct_pkg::MODE_READ :
             (sel < 95) ? mwct_pkg::MODE_CLEAR : mwct_pkg::MODE_NONE;
      // small key and hash pools so records fill up and hashes repeat
      key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
      h   = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 23));
      case ($urandom_range(0, 5))
        0:       w = 16'h7fff;
        1:       w = 16'h8000;
        2:       w = 16'($signed($urandom_range(0, 40)) - 20);
        default: w = 16'($urandom);
      endcase
      send_item(mode, key, h, w);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled set, absent read, unused mode, clear
    send_item(mwct_pkg::MODE_SET, 16'h0001, 31'd5, 16'd100);
    send_item(mwct_pkg::MODE_READ, 16'h0005, 31'd0, 16'd0);
    send_item(mwct_pkg::MODE_NONE, 16'hffff, 31'h7fffffff, 16'hffff);
    send_item(mwct_pkg::MODE_CLEAR, 16'h0000, 31'd0, 16'd0);
    write_enable(1'b1);
    // clamping at both ends, then an update of an existing hash
    send_item(mwct_pkg::MODE_SET, 16'h0000, 31'h7fffffff, 16'h7fff);
    send_item(mwct_pkg::MODE_SET, 16'h0000, 31'h00000000, 16'h8000);
    send_item(mwct_pkg::MODE_SET, 16'h0000, 31'h00000000, 16'h0001);
    // fill one record, then a rejected and an accepted replacement
    for (int i = 0; i < 16; i++)
      send_item(mwct_pkg::MODE_SET, 16'hffff, 31'(i * 977), 16'(200 + i));
    send_item(mwct_pkg::MODE_SET, 16'hffff, 31'd12345, 16'd50);
    send_item(mwct_pkg::MODE_SET, 16'hffff, 31'd12346, 16'hec78);
    long_hold_req = 1;
    send_item(mwct_pkg::MODE_READ, 16'hffff, 31'd0, 16'd0);
    send_item(mwct_pkg::MODE_READ, 16'h0000, 31'd0, 16'd0);
    send_item(mwct_pkg::MODE_READ, 16'h0003, 31'd0, 16'd0);

    random_items(12);
    write_enable(1'b0);
    random_items(6);
    write_enable(1'b1);

    // full table: every slot taken, then one more entity
    send_item(mwct_pkg::MODE_CLEAR, 16'h0000, 31'd0, 16'd0);
    for (int i = 0; i < mwct_pkg::EntitySlots; i++)
      send_item(mwct_pkg::MODE_SET, 16'(i * 131 + 7), 31'($urandom), 16'($urandom));
    send_item(mwct_pkg::MODE_SET, 16'hbeef, 31'd1, 16'd1);
    send_item(mwct_pkg::MODE_READ, 16'(255 * 131 + 7), 31'd0, 16'd0);
    send_item(mwct_pkg::MODE_SET, 16'(255 * 131 + 7), 31'd9, 16'd9);
    random_items(4);
    send_item(mwct_pkg::MODE_CLEAR, 16'h0000, 31'd0, 16'd0);

    random_items(10);
    quiet = 1;
    random_items(8);
    s_axis_tvalid <= 1'b0;

    while (table_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (table_sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", table_sb.expected_q.size());
      table_sb.errors++;
    end
    if (table_sb.errors == 0)
      $display("[morph_weight_channel_table_top] OK");
    else
      $display("[morph_weight_channel_table_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
